@@ rtl/core/positional_list_engine_core_macros.svh @@
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

// clocked check, off while reset is asserted
`define PLE_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// implication checked on every clock edge
`define PLE_ASSERT_IMPL(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

`endif

@@ rtl/core/ple_pkg.sv @@
package ple_pkg;

	localparam int DATA_W   = 32;
	localparam int ACTION_W = 3;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_RETRIEVE = 3'd0,
		ACT_INSERT   = 3'd1,
		ACT_REMOVE   = 3'd2,
		ACT_REPLACE  = 3'd3,
		ACT_CLEAR    = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_REPLACE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

@@ rtl/core/positional_list_engine_core.sv @@
// Ordered list of up to CAPACITY signed 32-bit entries addressed by position. Each request
// (retrieve, insert, remove, replace, clear) yields one response with status, value read and
// entry count; a new request is taken every cycle while the response register is empty or
// being drained. Inserts and removes shift the list through a row of CAPACITY entry cells,
// each loading from its lower or upper neighbor at once, so the cost per request does not
// depend on the position. Entries need no clearing after reset; only the entry count and the
// response valid flag are reset. The count field carries the low five bits of the entry count.
`include "positional_list_engine_core_macros.svh"

module positional_list_engine_core #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // action[2:0], position[7:3], value_in[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // status[1:0], value_out[33:2], count[38:34], zero[39]
);
	import ple_pkg::*;

	localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

	logic [ACTION_W-1:0] action;
	logic [POS_W-1:0]    position;
	logic [DATA_W-1:0]   value_in;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic              m_tvalid_q;
	logic [39:0]       m_tdata_q;
	logic              s_acc;
	logic [CMPW-1:0]   pos_c;
	logic [CMPW-1:0]   cnt_c;
	logic [IW-1:0]     pos_idx;
	logic              in_range;
	logic              ins_range;
	logic              full;
	status_t           res_status;
	logic [DATA_W-1:0] res_value;
	logic [DATA_W-1:0] rd_value;
	cell_cmd_t         cmd;
	logic [DATA_W-1:0] cell_val [CAPACITY];

	assign action   = s_tdata[2:0];
	assign position = s_tdata[7:3];
	assign value_in = s_tdata[39:8];

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	assign pos_c     = CMPW'(position);
	assign cnt_c     = CMPW'(count_q);
	assign pos_idx   = IW'(position);
	assign in_range  = pos_c < cnt_c;
	assign ins_range = pos_c <= cnt_c;
	assign full      = cnt_c == CAP_C;
	assign rd_value  = cell_val[pos_idx];

	always_comb begin
		res_status = ST_OK;
		res_value  = '0;
		count_d    = count_q;
		cmd.op     = CELL_HOLD;
		cmd.value  = value_in;
		unique case (action)
			ACT_RETRIEVE: begin
				if (!in_range) begin
					res_status = ST_RANGE;
				end else begin
					res_value = rd_value;
				end
			end
			ACT_INSERT: begin
				if (!ins_range) begin
					res_status = ST_RANGE;
				end else if (full) begin
					res_status = ST_FULL;
				end else begin
					cmd.op  = CELL_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (!in_range) begin
					res_status = ST_RANGE;
				end else begin
					res_value = rd_value;
					cmd.op    = CELL_REMOVE;
					count_d   = count_q - 1'b1;
				end
			end
			ACT_REPLACE: begin
				if (!in_range) begin
					res_status = ST_RANGE;
				end else begin
					cmd.op = CELL_REPLACE;
				end
			end
			ACT_CLEAR: count_d = '0;
			default: res_status = ST_RANGE;
		endcase
		if (!s_acc) begin
			cmd.op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ple_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.pos   (pos_idx),
			.left  ((i == 0) ? cell_val[0] : cell_val[(i == 0) ? 0 : i - 1]),
			.right (cell_val[(i == CAPACITY - 1) ? i : i + 1]),
			.value (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_tdata_q <= {1'b0, COUNT_W'(count_d), res_value, res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PLE_ASSERT(a_count_bound, CMPW'(count_q) <= CAP_C, "entry count beyond capacity")
	`PLE_ASSERT_IMPL(a_full_only_at_cap, s_acc && res_status == ST_FULL, full,
		"full status below capacity")
	`PLE_ASSERT_IMPL(a_clear_empties, s_acc && action == ACT_CLEAR,
		##1 (count_q == '0 && m_tvalid), "clear did not empty the list")
	`PLE_ASSERT_IMPL(a_insert_counts, s_acc && action == ACT_INSERT && res_status == ST_OK,
		##1 (count_q == CW'($past(count_q) + 1'b1)), "insert did not bump the count")

endmodule

@@ rtl/core/ple_cell.sv @@
module ple_cell #(
	parameter int IDX = 0,
	parameter int IW  = 4
) (
	input  logic                      clk,
	input  ple_pkg::cell_cmd_t        cmd,
	input  logic [IW-1:0]             pos,
	input  logic [ple_pkg::DATA_W-1:0] left,
	input  logic [ple_pkg::DATA_W-1:0] right,
	output logic [ple_pkg::DATA_W-1:0] value
);
	import ple_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] value_d;

	always_comb begin
		value_d = value_q;
		unique case (cmd.op)
			CELL_HOLD: value_d = value_q;
			CELL_INSERT: begin
				if (MY_IDX == pos) begin
					value_d = cmd.value;
				end else if (MY_IDX > pos) begin
					value_d = left;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= pos) begin
					value_d = right;
				end
			end
			CELL_REPLACE: begin
				if (MY_IDX == pos) begin
					value_d = cmd.value;
				end
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

@@ test/tb_positional_list_engine_core.sv @@
module tb_positional_list_engine_core;
	import ple_pkg::*;

	localparam int LIST_CAP = 16;
	localparam int RAND_ITEMS = 800;
	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 10;
	localparam logic [ACTION_W-1:0] ACT_BAD_LO = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_BAD_HI = 3'd7;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   value;
		logic [COUNT_W-1:0]  count;
	} list_resp_t;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [POS_W-1:0]    pos;
		logic [DATA_W-1:0]   val;
		logic                typed;
		list_resp_t          resp;
	} dir_row_t;

	localparam int DIR_ROWS = 24;
	localparam int FILL_AT = 17;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{ACT_RETRIEVE, 5'd0,  32'd0,          1'b1, '{ST_RANGE, 32'd0, 5'd0}},
		'{ACT_REMOVE,   5'd0,  32'd0,          1'b1, '{ST_RANGE, 32'd0, 5'd0}},
		'{ACT_REPLACE,  5'd0,  32'd1,          1'b1, '{ST_RANGE, 32'd0, 5'd0}},
		'{ACT_INSERT,   5'd1,  32'd5,          1'b1, '{ST_RANGE, 32'd0, 5'd0}},
		'{ACT_INSERT,   5'd0,  32'h7fffffff,   1'b1, '{ST_OK,    32'd0, 5'd1}},
		'{ACT_INSERT,   5'd0,  32'h80000000,   1'b1, '{ST_OK,    32'd0, 5'd2}},
		'{ACT_INSERT,   5'd2,  32'hffffffff,   1'b1, '{ST_OK,    32'd0, 5'd3}},
		'{ACT_INSERT,   5'd1,  32'd0,          1'b0, '{ST_OK,    32'd0, 5'd0}},
		'{ACT_RETRIEVE, 5'd0,  32'd0,          1'b0, '{ST_OK,    32'd0, 5'd0}},
		'{ACT_REPLACE,  5'd3,  32'ha5a5a5a5,   1'b0, '{ST_OK,    32'd0, 5'd0}},
		'{ACT_REPLACE,  5'd4,  32'd0,          1'b1, '{ST_RANGE, 32'd0, 5'd4}},
		'{ACT_REMOVE,   5'd0,  32'd0,          1'b0, '{ST_OK,    32'd0, 5'd0}},
		'{ACT_REMOVE,   5'd2,  32'd0,          1'b0, '{ST_OK,    32'd0, 5'd0}},
		'{ACT_BAD_LO,   5'd0,  32'd0,          1'b1, '{ST_RANGE, 32'd0, 5'd2}},
		'{ACT_BAD_HI,   5'd31, 32'hffffffff,   1'b1, '{ST_RANGE, 32'd0, 5'd2}},
		'{ACT_RETRIEVE, 5'd31, 32'd0,          1'b1, '{ST_RANGE, 32'd0, 5'd2}},
		'{ACT_CLEAR,    5'd31, 32'hffffffff,   1'b1, '{ST_OK,    32'd0, 5'd0}},
		'{ACT_INSERT,   5'd16, 32'd1,          1'b1, '{ST_FULL,  32'd0, 5'd16}},
		'{ACT_INSERT,   5'd17, 32'd1,          1'b1, '{ST_RANGE, 32'd0, 5'd16}},
		'{ACT_INSERT,   5'd0,  32'd1,          1'b1, '{ST_FULL,  32'd0, 5'd16}},
		'{ACT_REPLACE,  5'd15, 32'hffffffff,   1'b0, '{ST_OK,    32'd0, 5'd0}},
		'{ACT_REMOVE,   5'd15, 32'd0,          1'b0, '{ST_OK,    32'd0, 5'd0}},
		'{ACT_REMOVE,   5'd0,  32'd0,          1'b0, '{ST_OK,    32'd0, 5'd0}},
		'{ACT_RETRIEVE, 5'd14, 32'd0,          1'b1, '{ST_RANGE, 32'd0, 5'd14}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	logic [DATA_W-1:0] list_mem [LIST_CAP];
	int                list_len = 0;
	list_resp_t        pending_resp [$];

	bit         row_typed = 1'b0;
	list_resp_t row_resp = '0;
	bit         quiet = 1'b0;
	bit         hold_off_go = 1'b0;

	int req_count = 0;
	int resp_count = 0;
	int err_count = 0;
	int full_hits = 0;
	int range_hits = 0;
	int stuck_cycles = 0;

	positional_list_engine_core #(
		.CAPACITY(LIST_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic list_resp_t apply_list_request(logic [ACTION_W-1:0] act,
			logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		list_resp_t r;
		int p;
		r = '0;
		r.status = ST_OK;
		p = int'(pos);
		case (act)
			ACT_RETRIEVE: begin
				if (p >= list_len) r.status = ST_RANGE;
				else r.value = list_mem[p];
			end
			ACT_INSERT: begin
				if (p > list_len) begin
					r.status = ST_RANGE;
				end else if (list_len >= LIST_CAP) begin
					r.status = ST_FULL;
				end else begin
					for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
					list_mem[p] = val;
					list_len++;
				end
			end
			ACT_REMOVE: begin
				if (p >= list_len) begin
					r.status = ST_RANGE;
				end else begin
					r.value = list_mem[p];
					for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			ACT_REPLACE: begin
				if (p >= list_len) r.status = ST_RANGE;
				else list_mem[p] = val;
			end
			ACT_CLEAR: begin
				list_len = 0;
			end
			default: begin
				r.status = ST_RANGE;
			end
		endcase
		r.count = COUNT_W'(list_len);
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h00000000;
			3: return 32'hffffffff;
			default: return $urandom;
		endcase
	endfunction

	// request and response checking, both sampled at the rising edge
	always @(posedge clk) begin
		list_resp_t pred;
		list_resp_t got;
		list_resp_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pred = apply_list_request(s_tdata[2:0], s_tdata[7:3], s_tdata[39:8]);
				if (pred.status == ST_FULL) full_hits++;
				if (pred.status == ST_RANGE) range_hits++;
				pending_resp.push_back(row_typed ? row_resp : pred);
				req_count++;
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[1:0], m_tdata[33:2], m_tdata[38:34]};
				resp_count++;
				if (pending_resp.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("unexpected response: status %0d value %h count %0d",
							got.status, got.value, got.count);
				end else begin
					want = pending_resp.pop_front();
					if (got !== want) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("response %0d: status %0d/%0d value %h/%h count %0d/%0d (exp/got)",
								resp_count, want.status, got.status, want.value, got.value,
								want.count, got.count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// response side back-pressure
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_go) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_off_go = 1'b0;
			end else begin
				m_tready = quiet || ($urandom_range(99) >= 12);
			end
		end
	end

	task automatic send_req(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val, input bit typed, input list_resp_t resp);
		if (!quiet && $urandom_range(99) < 12) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {val, pos, act};
		row_typed = typed;
		row_resp = resp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(input bit grow);
		int r;
		logic [ACTION_W-1:0] act;
		logic [POS_W-1:0] pos;
		r = $urandom_range(99);
		if (r < 12) begin
			act = ACTION_W'($urandom_range(7, 0));
			pos = POS_W'($urandom_range(31, 0));
		end else begin
			r = $urandom_range(99);
			if (r < (grow ? 50 : 20)) act = ACT_INSERT;
			else if (r < 70) act = ACT_REMOVE;
			else if (r < 84) act = ACT_RETRIEVE;
			else if (r < 98) act = ACT_REPLACE;
			else act = ACT_CLEAR;
			if (act == ACT_INSERT) pos = POS_W'($urandom_range(list_len, 0));
			else if (list_len > 0) pos = POS_W'($urandom_range(list_len - 1, 0));
			else pos = POS_W'($urandom_range(31, 0));
		end
		send_req(act, pos, rand_value(), 1'b0, '0);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_resp.size() != 0) @(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == FILL_AT)
				for (int k = 0; k < LIST_CAP; k++)
					send_req(ACT_INSERT, POS_W'($urandom_range(list_len, 0)), rand_value(),
						1'b0, '0);
			send_req(DIR_TABLE[i].act, DIR_TABLE[i].pos, DIR_TABLE[i].val,
				DIR_TABLE[i].typed, DIR_TABLE[i].resp);
		end
		wait_drained();

		// long response stall while requests keep coming
		hold_off_go = 1'b1;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == 300) quiet = 1'b1;
			if (n == 450) quiet = 1'b0;
			if (n == 600) wait_drained();
			send_random(((n / 80) % 2) == 0);
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests and %0d responses, %0d list-full and %0d out-of-range cases",
			req_count, resp_count, full_hits, range_hits);
		$display("%0d mismatches, %0d responses still outstanding", err_count,
			pending_resp.size());
		if (err_count == 0 && pending_resp.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
